// ===== rtl/core/nmea_lcc_pkg.sv =====
// Shared types, constants and helpers for the NMEA line checksum checker.
`timescale 1ns / 1ps
`default_nettype none

package nmea_lcc_pkg;

    // Line store size and position counter width
    localparam int          POS_W         = 8;
    localparam logic [7:0]  LINE_CAPACITY = 8'd128;
    localparam int          LIMIT_W       = 7;
    localparam logic [6:0]  SCAN_LIMIT_RST = 7'd75;

    // Character codes
    localparam logic [7:0]  CH_NEWLINE = 8'h0A;
    localparam logic [7:0]  CH_DOLLAR  = 8'h24;
    localparam logic [7:0]  CH_STAR    = 8'h2A;
    localparam logic [7:0]  CH_NUL     = 8'h00;

    // Length needed before a line can be classed
    localparam logic [7:0]  KIND_MIN_LEN = 8'd6;

    // Sentence kinds
    localparam logic [1:0]  KIND_OTHER = 2'd0;
    localparam logic [1:0]  KIND_GGA   = 2'd1;
    localparam logic [1:0]  KIND_GLL   = 2'd2;
    localparam logic [1:0]  KIND_RMC   = 2'd3;

    // Output tdata width (fields packed, padded to whole bytes)
    localparam int          OUT_TDATA_W = 24;

    // Scan phase of the current line
    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_SCAN   = 3'd1,
        PH_DIGIT1 = 3'd2,
        PH_DIGIT2 = 3'd3,
        PH_DONE   = 3'd4,
        PH_FAIL   = 3'd5
    } phase_t;

    // Verdict for one line
    typedef struct packed {
        logic        checksum_ok;
        logic [1:0]  sentence_kind;
        logic [7:0]  computed_checksum;
        logic [7:0]  line_length;
        logic        overflowed;
    } result_t;

    // Line tracker to output stage
    typedef struct packed {
        logic    line_end;
        result_t result;
    } line_evt_t;

    // Uppercase hex digit of the low nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nibble);
        logic [7:0] r;
        if (nibble < 4'd10)
        begin
            r = 8'h30 + {4'd0, nibble};
        end
        else
        begin
            r = 8'h41 + {4'd0, nibble} - 8'd10;
        end
        return r;
    endfunction

    // Expected character of prefix k (0 GGA, 1 GLL, 2 RMC) after '$', slot p = 0..4
    function automatic logic [7:0] prefix_char(input logic [1:0] k, input logic [2:0] p);
        logic [7:0] c;
        c = 8'h00;
        case (p)
            3'd0: c = 8'h47;                                   // G
            3'd1: c = 8'h50;                                   // P
            3'd2: c = (k == 2'd2) ? 8'h52 : 8'h47;             // R / G
            3'd3: c = (k == 2'd0) ? 8'h47 :
                      (k == 2'd1) ? 8'h4C : 8'h4D;             // G / L / M
            3'd4: c = (k == 2'd0) ? 8'h41 :
                      (k == 2'd1) ? 8'h4C : 8'h43;             // A / L / C
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/nmea_lcc_line.sv =====
// Per-line tracker: scan state, running XOR, digits, prefix match and verdict.
`timescale 1ns / 1ps
`default_nettype none

module nmea_lcc_line
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [6:0]                scan_limit,
    input  wire logic                      take,
    input  wire logic [7:0]                rx_byte,
    output nmea_lcc_pkg::line_evt_t        evt
);
    import nmea_lcc_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  dig1_reg, dig1_next;
    logic [7:0]  dig2_reg, dig2_next;
    logic [2:0]  match_reg, match_next;

    logic        full;
    logic        line_end;
    logic        scan_stop;
    logic        in_prefix;
    logic [2:0]  slot;
    logic [2:0]  match_upd;
    logic        ok;
    logic [1:0]  kind;

    // Line end on newline or when the store is already full
    assign full      = (pos_reg >= LINE_CAPACITY);
    assign line_end  = (rx_byte == CH_NEWLINE) || full;
    assign scan_stop = (pos_reg >= {1'b0, scan_limit}) || (rx_byte == CH_NUL);

    // Prefix compare for positions 1..5
    assign in_prefix = (pos_reg >= 8'd1) && (pos_reg <= 8'd5);
    assign slot      = pos_reg[2:0] - 3'd1;

    always_comb
    begin
        match_upd = match_reg;
        if (in_prefix)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (rx_byte != prefix_char(2'(k), slot))
                begin
                    match_upd[k] = 1'b0;
                end
            end
        end
    end

    // Next scan phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_START:  phase_next = (rx_byte == CH_DOLLAR) ? PH_SCAN : PH_FAIL;
            PH_SCAN:
            begin
                if (scan_stop)
                begin
                    phase_next = PH_FAIL;
                end
                else if (rx_byte == CH_STAR)
                begin
                    phase_next = PH_DIGIT1;
                end
            end
            PH_DIGIT1: phase_next = PH_DIGIT2;
            PH_DIGIT2: phase_next = PH_DONE;
            PH_DONE:   phase_next = PH_DONE;
            PH_FAIL:   phase_next = PH_FAIL;
            default:   phase_next = PH_FAIL;
        endcase
    end

    // Datapath updates per phase
    always_comb
    begin
        xor_next  = xor_reg;
        dig1_next = dig1_reg;
        dig2_next = dig2_reg;
        unique case (phase_reg)
            PH_SCAN:
            begin
                if (!scan_stop && (rx_byte != CH_STAR))
                begin
                    xor_next = xor_reg ^ rx_byte;
                end
            end
            PH_DIGIT1: dig1_next = rx_byte;
            PH_DIGIT2: dig2_next = rx_byte;
            default:   xor_next  = xor_reg;
        endcase
        match_next = match_upd;
        pos_next   = pos_reg + 8'd1;
    end

    // Line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            pos_reg   <= '0;
            xor_reg   <= '0;
            dig1_reg  <= '0;
            dig2_reg  <= '0;
            match_reg <= 3'b111;
        end
        else if (take)
        begin
            if (line_end)
            begin
                phase_reg <= PH_START;
                pos_reg   <= '0;
                xor_reg   <= '0;
                dig1_reg  <= '0;
                dig2_reg  <= '0;
                match_reg <= 3'b111;
            end
            else
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                xor_reg   <= xor_next;
                dig1_reg  <= dig1_next;
                dig2_reg  <= dig2_next;
                match_reg <= match_next;
            end
        end
    end

    // Verdict for the line as it stands
    assign ok = (phase_reg == PH_DONE)
             && (dig1_reg == hex_char(xor_reg[7:4]))
             && (dig2_reg == hex_char(xor_reg[3:0]));

    always_comb
    begin
        kind = KIND_OTHER;
        if (ok && (pos_reg >= KIND_MIN_LEN))
        begin
            if (match_reg[0])
            begin
                kind = KIND_GGA;
            end
            else if (match_reg[1])
            begin
                kind = KIND_GLL;
            end
            else if (match_reg[2])
            begin
                kind = KIND_RMC;
            end
        end
    end

    assign evt.line_end                 = line_end;
    assign evt.result.checksum_ok       = ok;
    assign evt.result.sentence_kind     = kind;
    assign evt.result.computed_checksum = xor_reg;
    assign evt.result.line_length       = pos_reg;
    assign evt.result.overflowed        = (rx_byte != CH_NEWLINE);

endmodule

`default_nettype wire

// ===== rtl/core/nmea_lcc_out_reg.sv =====
// Result register: holds one line verdict until the master side takes it.
`timescale 1ns / 1ps
`default_nettype none

module nmea_lcc_out_reg
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire nmea_lcc_pkg::result_t  result_in,
    input  wire logic                   out_ready,
    output logic                        out_valid,
    output nmea_lcc_pkg::result_t       result_out
);
    import nmea_lcc_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // Valid flag: set on load, cleared when the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = res_reg;

endmodule

`default_nettype wire

// ===== rtl/core/nmea_line_checksum_checker_top.sv =====
// Top level of the NMEA line checksum checker.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+---------------------------------------------
//  s_axis   | in  | s_tvalid/s_tready | s_tdata[7:0] = rx_byte
//  m_axis   | out | m_tvalid/m_tready | m_tdata = ok,xor,length,overflow; m_tuser = kind
//  cfg      | in  | cfg_we            | cfg_wdata[6:0] = scan_limit
//
//  One byte per cycle while s_tready is high: each byte updates the line state registers.
//  A line end loads the verdict into the result register; it is shown the next cycle.
//  s_tready drops only while a result waits and m_tready is low.
//  Reset clears the line state and sets scan_limit to 75.
`timescale 1ns / 1ps
`default_nettype none

module nmea_line_checksum_checker_top
(
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    // config
    input  wire logic                                      cfg_we,
    input  wire logic [6:0]                                cfg_wdata,
    // input stream
    input  wire logic                                      s_tvalid,
    output logic                                           s_tready,
    input  wire logic [7:0]                                s_tdata,   // [7:0] rx_byte
    // result stream
    output logic                                           m_tvalid,
    input  wire logic                                      m_tready,
    // [0] checksum_ok, [8:1] computed_checksum, [16:9] line_length,
    // [17] overflowed, [23:18] zero
    output logic [nmea_lcc_pkg::OUT_TDATA_W-1:0]           m_tdata,
    output logic [1:0]                                     m_tuser    // [1:0] sentence_kind
);
    import nmea_lcc_pkg::*;

    logic [6:0] scan_limit_reg;
    logic       take;
    line_evt_t  evt;
    result_t    res;

    // Scan limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_limit_reg <= SCAN_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            scan_limit_reg <= cfg_wdata;
        end
    end

    // Accept while the result register is free or draining
    assign s_tready = !m_tvalid || m_tready;
    assign take     = s_tvalid && s_tready;

    nmea_lcc_line u_line
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_limit (scan_limit_reg),
        .take       (take),
        .rx_byte    (s_tdata),
        .evt        (evt)
    );

    nmea_lcc_out_reg u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take && evt.line_end),
        .result_in  (evt.result),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .result_out (res)
    );

    // Pack result fields
    assign m_tdata = {6'd0, res.overflowed, res.line_length,
                      res.computed_checksum, res.checksum_ok};
    assign m_tuser = res.sentence_kind;

endmodule

`default_nettype wire

// ===== rtl/core/nmea_lcc_checker.sv =====
// Port-level checks for the NMEA line checksum checker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module nmea_lcc_checker
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [6:0]                            cfg_wdata,
    input  wire logic                                  s_tvalid,
    input  wire logic                                  s_tready,
    input  wire logic [7:0]                            s_tdata,
    input  wire logic                                  m_tvalid,
    input  wire logic                                  m_tready,
    input  wire logic [nmea_lcc_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  wire logic [1:0]                            m_tuser
);
    import nmea_lcc_pkg::*;

    logic unused_cfg;
    assign unused_cfg = cfg_we ^ (|cfg_wdata);

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Input side never blocked while no result waits
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // Accepted newline yields a result
    a_newline: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata == CH_NEWLINE) |=> m_tvalid)
        else $error("newline without result");

    // A classed sentence must have passed the checksum
    a_kind_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != KIND_OTHER) |-> m_tdata[0])
        else $error("kind set on failed line");

    // Overflow only with a full store
    a_ovf_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[17] |-> (m_tdata[16:9] == LINE_CAPACITY))
        else $error("overflow with short line");

endmodule

bind nmea_line_checksum_checker_top nmea_lcc_checker u_nmea_lcc_checker (.*);

`default_nettype wire

// ===== tb/sv/nmea_verdict_checker.sv =====
// Line verdict checker: tracks the byte stream, predicts each line verdict, compares results.
`timescale 1ns / 1ps

module nmea_verdict_checker
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [6:0]                           cfg_wdata,
    input  wire logic                                 s_tvalid,
    input  wire logic                                 s_tready,
    input  wire logic [7:0]                           s_tdata,
    input  wire logic                                 m_tvalid,
    input  wire logic                                 m_tready,
    input  wire logic [nmea_lcc_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  wire logic [1:0]                           m_tuser,
    output int                                        mismatches,
    output int                                        pending_lines,
    output int                                        lines_checked,
    output int                                        good_lines,
    output int                                        overflow_lines
);

    import nmea_lcc_pkg::*;

    // Talker/sentence ids after '$', GGA in the top 40 bits, RMC in the bottom
    localparam logic [119:0] SENTENCE_IDS = {"GPGGA", "GPGLL", "GPRMC"};
    localparam logic [127:0] HEX_DIGITS   = "0123456789ABCDEF";

    // Predicted line state
    logic [7:0] line_pos;
    logic [7:0] star_xor;
    logic [7:0] hi_digit;
    logic [7:0] lo_digit;
    logic [2:0] id_hits;
    logic [6:0] scan_limit_q;
    phase_t     scan_ph;

    result_t    verdict_q[$];

    function automatic logic [7:0] id_char(input int k, input int slot);
        return SENTENCE_IDS[8 * (5 * (2 - k) + (4 - slot)) +: 8];
    endfunction

    function automatic logic [7:0] hex_ascii(input logic [3:0] n);
        int idx;
        idx = 15 - int'(n);
        return HEX_DIGITS[8 * idx +: 8];
    endfunction

    task automatic clear_line();
        line_pos = 8'd0;
        star_xor = 8'd0;
        hi_digit = 8'd0;
        lo_digit = 8'd0;
        id_hits  = 3'b111;
        scan_ph  = PH_START;
    endtask

    // One accepted byte: absorb it, or close the line and queue its verdict
    task automatic predict_line_byte(input logic [7:0] b);
        result_t v;
        int      k;
        if (b != CH_NEWLINE && line_pos < LINE_CAPACITY)
        begin
            if (line_pos >= 8'd1 && line_pos <= 8'd5)
            begin
                for (k = 0; k < 3; k++)
                begin
                    if (b != id_char(k, int'(line_pos) - 1))
                        id_hits[k] = 1'b0;
                end
            end
            case (scan_ph)
                PH_START:
                begin
                    scan_ph = (b == CH_DOLLAR) ? PH_SCAN : PH_FAIL;
                end
                PH_SCAN:
                begin
                    if (line_pos >= {1'b0, scan_limit_q} || b == CH_NUL)
                        scan_ph = PH_FAIL;
                    else if (b == CH_STAR)
                        scan_ph = PH_DIGIT1;
                    else
                        star_xor = star_xor ^ b;
                end
                PH_DIGIT1:
                begin
                    hi_digit = b;
                    scan_ph  = PH_DIGIT2;
                end
                PH_DIGIT2:
                begin
                    lo_digit = b;
                    scan_ph  = PH_DONE;
                end
                default:
                begin
                end
            endcase
            line_pos = line_pos + 8'd1;
        end
        else
        begin
            v.checksum_ok = (scan_ph == PH_DONE) && (hi_digit == hex_ascii(star_xor[7:4]))
                            && (lo_digit == hex_ascii(star_xor[3:0]));
            v.sentence_kind = KIND_OTHER;
            if (v.checksum_ok && line_pos >= KIND_MIN_LEN)
            begin
                if (id_hits[0])
                    v.sentence_kind = KIND_GGA;
                else if (id_hits[1])
                    v.sentence_kind = KIND_GLL;
                else if (id_hits[2])
                    v.sentence_kind = KIND_RMC;
            end
            v.computed_checksum = star_xor;
            v.line_length       = line_pos;
            v.overflowed        = (b != CH_NEWLINE);
            verdict_q.push_back(v);
            clear_line();
        end
    endtask

    // One result transfer against the oldest predicted verdict
    task automatic check_verdict();
        result_t want;
        result_t got;
        got.checksum_ok       = m_tdata[0];
        got.computed_checksum = m_tdata[8:1];
        got.line_length       = m_tdata[16:9];
        got.overflowed        = m_tdata[17];
        got.sentence_kind     = m_tuser;
        lines_checked <= lines_checked + 1;
        if (verdict_q.size() == 0)
        begin
            if (mismatches < 10)
                $display("%0t: unexpected verdict ok=%0d kind=%0d xor=%02h len=%0d ovf=%0d",
                         $realtime, got.checksum_ok, got.sentence_kind,
                         got.computed_checksum, got.line_length, got.overflowed);
            mismatches <= mismatches + 1;
        end
        else
        begin
            want = verdict_q.pop_front();
            if (got.checksum_ok != want.checksum_ok || got.sentence_kind != want.sentence_kind
                || got.computed_checksum != want.computed_checksum
                || got.line_length != want.line_length || got.overflowed != want.overflowed)
            begin
                if (mismatches < 10)
                    $display("%0t: verdict mismatch exp ok=%0d kind=%0d xor=%02h len=%0d ovf=%0d",
                             $realtime, want.checksum_ok, want.sentence_kind,
                             want.computed_checksum, want.line_length, want.overflowed,
                             "  got ok=%0d kind=%0d xor=%02h len=%0d ovf=%0d",
                             got.checksum_ok, got.sentence_kind, got.computed_checksum,
                             got.line_length, got.overflowed);
                mismatches <= mismatches + 1;
            end
            if (want.checksum_ok)
                good_lines <= good_lines + 1;
            if (want.overflowed)
                overflow_lines <= overflow_lines + 1;
        end
    endtask

    // Results are checked before the byte of the same edge.
    // A limit written at an edge applies from the next byte on.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_line();
            scan_limit_q = SCAN_LIMIT_RST;
            verdict_q.delete();
            mismatches     <= 0;
            pending_lines  <= 0;
            lines_checked  <= 0;
            good_lines     <= 0;
            overflow_lines <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_verdict();
            if (s_tvalid && s_tready)
                predict_line_byte(s_tdata);
            if (cfg_we)
                scan_limit_q = cfg_wdata;
            pending_lines <= verdict_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top: clock, reset, byte stimulus, result sink and final verdict.
`timescale 1ns / 1ps

module tb_top;

    import nmea_lcc_pkg::*;

    localparam int IDLE_LIMIT      = 1000;
    localparam int LINES_PER_LIMIT = 2;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [6:0]             cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]             m_tuser;

    int mismatches;
    int pending_lines;
    int lines_checked;
    int good_lines;
    int overflow_lines;

    int bytes_sent;
    int cfg_writes;
    int cfg_phase;
    int lines_in_phase;
    int idle_cycles = 0;
    bit tx_no_idle;
    bit rx_no_idle;

    logic [7:0] line_buf[$];

    nmea_line_checksum_checker_top u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    nmea_verdict_checker u_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatches     (mismatches),
        .pending_lines  (pending_lines),
        .lines_checked  (lines_checked),
        .good_lines     (good_lines),
        .overflow_lines (overflow_lines)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: too long without any transfer on either stream
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Result sink: random stall before taking each verdict
    initial
    begin : sink
        int gap;
        m_tready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            gap = rx_no_idle ? 0 : $urandom_range(0, 12);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    function automatic logic [7:0] hex_ascii(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
    endfunction

    // Send one byte after a random gap; valid stays high when the gap is zero
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_line(input bit with_newline);
        int i;
        for (i = 0; i < line_buf.size(); i++)
            send_byte(line_buf[i]);
        if (with_newline)
            send_byte(CH_NEWLINE);
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    // Build '$' + sentence id + printable body + '*' + checksum; id 4 means no id
    task automatic make_sentence(input int id_sel, input int body_len);
        logic [39:0] id_text;
        logic [7:0]  sum;
        logic [7:0]  c8;
        int          i;
        line_buf.delete();
        line_buf.push_back(CH_DOLLAR);
        case (id_sel)
            0: id_text = "GPGGA";
            1: id_text = "GPGLL";
            2: id_text = "GPRMC";
            default:
            begin
                for (i = 0; i < 5; i++)
                    id_text[8 * i +: 8] = 8'($urandom_range(8'h41, 8'h5A));
            end
        endcase
        if (id_sel < 4)
        begin
            for (i = 4; i >= 0; i--)
                line_buf.push_back(id_text[8 * i +: 8]);
        end
        for (i = 0; i < body_len; i++)
        begin
            c8 = 8'($urandom_range(8'h20, 8'h7E));
            if (c8 == CH_STAR)
                c8 = ",";
            line_buf.push_back(c8);
        end
        sum = 8'd0;
        for (i = 1; i < line_buf.size(); i++)
            sum = sum ^ line_buf[i];
        line_buf.push_back(CH_STAR);
        line_buf.push_back(hex_ascii(sum[7:4]));
        line_buf.push_back(hex_ascii(sum[3:0]));
    endtask

    // Mostly well-formed sentences, some damaged, the rest byte noise
    task automatic random_line();
        int         n;
        int         idx;
        int         i;
        logic [7:0] c8;
        if ($urandom_range(0, 99) < 70)
        begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 130) : $urandom_range(0, 10);
            make_sentence($urandom_range(0, 4), n);
            case ($urandom_range(0, 9))
                5:
                begin
                    // trailing bytes after the digits
                    n = $urandom_range(1, 3);
                    for (i = 0; i < n; i++)
                        line_buf.push_back(8'($urandom_range(0, 255)));
                end
                6:
                begin
                    idx = $urandom_range(1, line_buf.size() - 1);
                    line_buf[idx] = line_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
                end
                7:
                begin
                    // lowercase checksum digits
                    for (i = line_buf.size() - 2; i < line_buf.size(); i++)
                        if (line_buf[i] >= "A" && line_buf[i] <= "F")
                            line_buf[i] = line_buf[i] + 8'h20;
                end
                8:
                begin
                    n = $urandom_range(1, 3);
                    for (i = 0; i < n; i++)
                        void'(line_buf.pop_back());
                end
                9:
                begin
                    void'(line_buf.pop_front());
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            line_buf.delete();
            n = $urandom_range(0, 12);
            for (i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 3))
                    2:       c8 = CH_DOLLAR;
                    3:       c8 = CH_STAR;
                    default: c8 = 8'($urandom_range(0, 255));
                endcase
                line_buf.push_back(c8);
            end
        end
        send_line(1'b1);
    endtask

    // Wait until every verdict is out, with a margin for the last byte
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_lines != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_scan_limit(input logic [6:0] v);
        drain();
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_writes++;
    endtask

    initial
    begin : stimulus
        int         i;
        logic [6:0] lim;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= 7'd0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'd0;
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
        bytes_sent = 0;
        cfg_writes = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines at the reset scan limit
        line_buf.delete();
        send_line(1'b1);                                 // empty line
        make_sentence(0, 3);
        send_line(1'b1);
        make_sentence(1, 0);
        send_line(1'b1);
        make_sentence(2, 6);
        send_line(1'b1);
        make_sentence(4, 0);                             // short valid, no id
        send_line(1'b1);
        line_buf.delete();
        push_text("X*00");                               // no start marker
        send_line(1'b1);
        line_buf.delete();
        push_text("$G");                                 // zero byte inside the scan
        line_buf.push_back(CH_NUL);
        push_text("*47");
        send_line(1'b1);
        make_sentence(2, 2);                             // zero after the digits is just data
        line_buf.push_back(CH_NUL);
        send_line(1'b1);
        line_buf.delete();
        push_text("$GPG");                               // ends during the scan
        send_line(1'b1);
        line_buf.delete();
        push_text("$G*4");                               // ends before the second digit
        send_line(1'b1);
        make_sentence(0, 4);                             // bad checksum
        line_buf[line_buf.size() - 1] = line_buf[line_buf.size() - 1] ^ 8'h01;
        send_line(1'b1);
        line_buf.delete();
        push_text("$J*4a");                              // lowercase digit
        send_line(1'b1);
        line_buf.delete();
        line_buf.push_back(CH_DOLLAR);                   // extreme byte values
        line_buf.push_back(8'hFF);
        line_buf.push_back(8'h80);
        push_text("*7F");
        send_line(1'b1);
        line_buf.delete();
        line_buf.push_back(CH_DOLLAR);                   // store full, then one more byte
        for (i = 0; i < 128; i++)
            line_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
        send_line(1'b1);

        // Random lines across several scan limits
        cfg_phase = 0;
        lines_in_phase = LINES_PER_LIMIT;
        while (bytes_sent < 400 || cfg_phase < 7)
        begin
            if (lines_in_phase == LINES_PER_LIMIT)
            begin
                case (cfg_phase)
                    0:       lim = 7'd127;
                    1:       lim = 7'd2;
                    2:       lim = 7'd0;
                    3:       lim = 7'd1;
                    4:       lim = 7'($urandom_range(3, 16));
                    5:       lim = SCAN_LIMIT_RST;
                    default: lim = 7'($urandom_range(2, 127));
                endcase
                set_scan_limit(lim);
                tx_no_idle = (cfg_phase % 3 == 1);
                rx_no_idle = (cfg_phase % 3 == 2);
                cfg_phase++;
                lines_in_phase = 0;
            end
            random_line();
            lines_in_phase++;
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Run covered %0d bytes and %0d line verdicts: %0d good checksums, %0d overflows",
                 bytes_sent, lines_checked, good_lines, overflow_lines);
        $display("Scan limit written %0d times, including 0, 1, 2 and 127", cfg_writes);
        if (mismatches == 0 && pending_lines == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/nmea_lcc_pkg.sv
rtl/core/nmea_lcc_line.sv
rtl/core/nmea_lcc_out_reg.sv
rtl/core/nmea_line_checksum_checker_top.sv
rtl/core/nmea_lcc_checker.sv
tb/sv/nmea_verdict_checker.sv
tb/sv/tb_top.sv
